// ===== hdl/sorted_list_engine_top_macros.svh =====
// Assertion helpers shared by the sorted list engine RTL.
// Each use names a label and checks on the rising edge of clock, off while reset is high.
`ifndef SORTED_LIST_ENGINE_TOP_MACROS_SVH
`define SORTED_LIST_ENGINE_TOP_MACROS_SVH

// Same-cycle implication.
`define SLE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted list engine check failed");

// Next-cycle implication.
`define SLE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted list engine check failed");

`endif

// ===== hdl/sle_pkg.sv =====
package sle_pkg;

   localparam int VALUE_W = 32;
   localparam int OP_W    = 2;
   localparam int COUNT_W = 5;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

   // One operation walking down the row of cells.
   typedef struct packed {
      logic               live;
      logic [OP_W-1:0]    kind;
      logic [VALUE_W-1:0] key;
      logic [VALUE_W-1:0] carry;
      logic               hit;
   } sle_token_type;

endpackage

// ===== hdl/sorted_list_engine_top.sv =====
// Sorted list engine: keeps up to DEPTH signed 32-bit values in ascending order
// in a row of DEPTH cells, one value per cell. Each request beat (insert,
// remove, query) launches a token that moves one cell per clock down the row;
// every cell compares, swaps or shifts locally as the token passes. One item
// is in flight at a time: a request goes from acceptance to the response beat
// through the launch register, the token walk over the DEPTH cells, the finish
// state and the output register. A response waiting on rsp_ready does not block
// the next request. Inserts into a full list are rejected and leave it unchanged.
`include "sorted_list_engine_top_macros.svh"

module sorted_list_engine_top #(
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [sle_pkg::OP_W-1:0]             req_op,
   input  logic signed [sle_pkg::VALUE_W-1:0]   req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_found,
   output logic [sle_pkg::COUNT_W-1:0]          rsp_count,
   output logic                                 rsp_rejected
);

   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                     state_ff, state_in;
   logic [CW-1:0]                  count_ff, count_in;
   sle_pkg::sle_token_type         tok_ff, tok_in;
   logic [sle_pkg::OP_W-1:0]       kind_ff, kind_in;
   logic                           rej_ff, rej_in;
   logic                           res_found_ff, res_found_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_found_ff, rsp_found_in;
   logic [sle_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                           rsp_rejected_ff, rsp_rejected_in;

   sle_pkg::sle_token_type         tok_chain [DEPTH+1];
   logic [CW-1:0]                  rem_chain [DEPTH+1];
   logic [sle_pkg::VALUE_W-1:0]    cell_value [DEPTH];
   logic [DEPTH:0]                 live_vec;

   logic                           accept;
   logic                           full;
   logic                           tail;

   assign accept = req_valid && req_ready;
   assign full   = (count_ff == CW'(DEPTH));
   assign tail   = tok_chain[DEPTH].live;

   assign tok_chain[0] = tok_ff;
   assign rem_chain[0] = count_ff;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic [sle_pkg::VALUE_W-1:0] nxt;
         if (gi == DEPTH - 1) begin : g_last
            assign nxt = cell_value[gi];
         end else begin : g_mid
            assign nxt = cell_value[gi+1];
         end
         sle_cell #(
            .CW (CW)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .prv_tok   (tok_chain[gi]),
            .prv_rem   (rem_chain[gi]),
            .nxt_value (nxt),
            .tok       (tok_chain[gi+1]),
            .rem       (rem_chain[gi+1]),
            .value     (cell_value[gi])
         );
      end
      for (gi = 0; gi <= DEPTH; gi++) begin : g_live
         assign live_vec[gi] = tok_chain[gi].live;
      end
   endgenerate

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      tok_in          = tok_ff;
      tok_in.live     = 1'b0;
      kind_in         = kind_ff;
      rej_in          = rej_ff;
      res_found_in    = res_found_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_found_in    = rsp_found_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_rejected_in = rsp_rejected_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rej_in       = (req_op == sle_pkg::OP_INSERT) && full;
               kind_in      = rej_in ? sle_pkg::OP_NOP : req_op;
               tok_in.live  = 1'b1;
               tok_in.kind  = kind_in;
               tok_in.key   = req_value;
               tok_in.carry = req_value;
               tok_in.hit   = 1'b0;
               state_in     = ST_WALK;
            end
         end
         ST_WALK: begin
            if (tail) begin
               res_found_in = tok_chain[DEPTH].hit;
               if (kind_ff == sle_pkg::OP_INSERT) begin
                  count_in = count_ff + CW'(1);
               end else if (kind_ff == sle_pkg::OP_REMOVE && tok_chain[DEPTH].hit) begin
                  count_in = count_ff - CW'(1);
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register frees up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = res_found_ff;
               rsp_count_in    = sle_pkg::COUNT_W'(count_ff);
               rsp_rejected_in = rej_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         tok_ff.live  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         tok_ff.live  <= tok_in.live;
         rsp_valid_ff <= rsp_valid_in;
      end
      tok_ff.kind     <= tok_in.kind;
      tok_ff.key      <= tok_in.key;
      tok_ff.carry    <= tok_in.carry;
      tok_ff.hit      <= tok_in.hit;
      kind_ff         <= kind_in;
      rej_ff          <= rej_in;
      res_found_ff    <= res_found_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_rejected_ff <= rsp_rejected_in;
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_rejected = rsp_rejected_ff;

   `SLE_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(DEPTH))
   `SLE_ASSERT_NOW(a_one_token, 1'b1, $onehot0(live_vec))
   `SLE_ASSERT_NEXT(a_launch, accept, tok_chain[0].live)
   `SLE_ASSERT_NOW(a_tail_in_walk, tail, state_ff == ST_WALK)
   `SLE_ASSERT_NOW(a_reject_full, rsp_valid_ff && rsp_rejected_ff,
      rsp_count_ff == sle_pkg::COUNT_W'(DEPTH))

endmodule

// ===== hdl/sle_cell.sv =====
module sle_cell #(
   parameter int CW = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sle_pkg::sle_token_type        prv_tok,
   input  logic [CW-1:0]                 prv_rem,
   input  logic [sle_pkg::VALUE_W-1:0]   nxt_value,
   output sle_pkg::sle_token_type        tok,
   output logic [CW-1:0]                 rem,
   output logic [sle_pkg::VALUE_W-1:0]   value
);

   sle_pkg::sle_token_type        tok_ff, tok_in;
   logic [CW-1:0]                 rem_ff, rem_in;
   logic [sle_pkg::VALUE_W-1:0]   value_ff, value_in;
   logic                          occupied;
   logic                          match;

   always_comb begin
      tok_in   = prv_tok;
      value_in = value_ff;
      occupied = (prv_rem != '0);
      rem_in   = occupied ? (prv_rem - CW'(1)) : '0;
      match    = occupied && (value_ff == prv_tok.key);
      if (prv_tok.live) begin
         case (prv_tok.kind)
            sle_pkg::OP_INSERT: begin
               if (!occupied) begin
                  // first free slot: drop the carried value here and retire
                  value_in    = prv_tok.carry;
                  tok_in.kind = sle_pkg::OP_NOP;
               end else if ($signed(value_ff) >= $signed(prv_tok.carry)) begin
                  value_in     = prv_tok.carry;
                  tok_in.carry = value_ff;
               end
            end
            sle_pkg::OP_REMOVE: begin
               // from the first match on, pull each entry down from the right
               if (prv_tok.hit || match) begin
                  value_in   = nxt_value;
                  tok_in.hit = 1'b1;
               end
            end
            sle_pkg::OP_QUERY: begin
               if (match) begin
                  tok_in.hit = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.live <= 1'b0;
      end else begin
         tok_ff.live <= tok_in.live;
      end
      tok_ff.kind  <= tok_in.kind;
      tok_ff.key   <= tok_in.key;
      tok_ff.carry <= tok_in.carry;
      tok_ff.hit   <= tok_in.hit;
      rem_ff       <= rem_in;
      value_ff     <= value_in;
   end

   assign tok   = tok_ff;
   assign rem   = rem_ff;
   assign value = value_ff;

endmodule

// ===== tb/testbench.sv =====
module testbench;

   localparam int LIST_DEPTH = 16;
   localparam int ITEMS_PER_PHASE = 180;

   typedef struct packed {
      logic                        found;
      logic [sle_pkg::COUNT_W-1:0] count;
      logic                        rejected;
   } list_result_type;

   // Mirror of the sorted multiset; each request beat yields one expected response.
   class sorted_list_scoreboard;
      logic signed [sle_pkg::VALUE_W-1:0] store[$];
      list_result_type awaited[$];
      int errors;

      function void note_request(logic [sle_pkg::OP_W-1:0] op,
                                 logic signed [sle_pkg::VALUE_W-1:0] value);
         list_result_type res;
         int pos;
         res = '0;
         case (op)
            sle_pkg::OP_INSERT: begin
               if (store.size() >= LIST_DEPTH) begin
                  res.rejected = 1'b1;
               end else begin
                  // newest of equal values goes first
                  pos = 0;
                  while (pos < store.size() && store[pos] < value) pos++;
                  store.insert(pos, value);
               end
            end
            sle_pkg::OP_REMOVE, sle_pkg::OP_QUERY: begin
               for (int i = 0; i < store.size(); i++) begin
                  if (store[i] == value) begin
                     res.found = 1'b1;
                     if (op == sle_pkg::OP_REMOVE) store.delete(i);
                     break;
                  end
                  if (store[i] > value) break;
               end
            end
            default: ;
         endcase
         res.count = sle_pkg::COUNT_W'(store.size());
         awaited.push_back(res);
      endfunction

      function void check_result(logic found, logic [sle_pkg::COUNT_W-1:0] count,
                                 logic rejected);
         list_result_type exp_res;
         if (awaited.size() == 0) begin
            $display("%0t: response beat with nothing outstanding (found %0b count %0d rej %0b)",
                     $time, found, count, rejected);
            errors++;
            return;
         end
         exp_res = awaited.pop_front();
         if (found !== exp_res.found) begin
            $display("%0t: found mismatch, expected %0b, actual %0b",
                     $time, exp_res.found, found);
            errors++;
         end
         if (count !== exp_res.count) begin
            $display("%0t: count mismatch, expected %0d, actual %0d",
                     $time, exp_res.count, count);
            errors++;
         end
         if (rejected !== exp_res.rejected) begin
            $display("%0t: rejected mismatch, expected %0b, actual %0b",
                     $time, exp_res.rejected, rejected);
            errors++;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [sle_pkg::OP_W-1:0] req_op = sle_pkg::OP_NOP;
   logic signed [sle_pkg::VALUE_W-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_found;
   logic [sle_pkg::COUNT_W-1:0] rsp_count;
   logic rsp_rejected;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   sorted_list_scoreboard sb;

   sorted_list_engine_top #(.DEPTH(LIST_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_found(rsp_found),
      .rsp_count(rsp_count),
      .rsp_rejected(rsp_rejected)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_found, rsp_count, rsp_rejected);
   end

   initial begin
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

   task automatic send_item(input logic [sle_pkg::OP_W-1:0] op,
                            input logic signed [sle_pkg::VALUE_W-1:0] value);
      req_valid <= 1'b1;
      req_op    <= op;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, value);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
   endtask

   // Hold off new requests until every response is back.
   task automatic drain_list();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic signed [sle_pkg::VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 35) return sle_pkg::VALUE_W'($signed($urandom_range(8)) - 4);
      if (r < 60 && sb.store.size() > 0) return sb.store[$urandom_range(sb.store.size() - 1)];
      if (r < 70) begin
         case ($urandom_range(3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh8000_0001;
            default: return 32'sh7fff_fffe;
         endcase
      end
      return $urandom;
   endfunction

   task automatic run_random(input int n_items);
      int insert_pct;
      int burst_left;
      int r;
      logic [sle_pkg::OP_W-1:0] op;
      insert_pct = 50;
      burst_left = 0;
      for (int i = 0; i < n_items; i++) begin
         // switch at random between fill, empty and mixed bursts so the list swings between ends
         if (burst_left == 0) begin
            burst_left = $urandom_range(15, 40);
            case ($urandom_range(2))
               0: insert_pct = 75;
               1: insert_pct = 20;
               default: insert_pct = 45;
            endcase
         end
         burst_left--;
         r = $urandom_range(99);
         if (r < 5) op = sle_pkg::OP_NOP;
         else if (r < 5 + insert_pct) op = sle_pkg::OP_INSERT;
         else if ($urandom_range(1)) op = sle_pkg::OP_REMOVE;
         else op = sle_pkg::OP_QUERY;
         send_item(op, pick_value());
      end
   endtask

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list, extremes, duplicates, early stop on remove, full list
      send_item(sle_pkg::OP_QUERY, 32'sd0);
      send_item(sle_pkg::OP_REMOVE, 32'sd5);
      send_item(sle_pkg::OP_NOP, 32'shffff_ffff);
      send_item(sle_pkg::OP_INSERT, 32'sh7fff_ffff);
      send_item(sle_pkg::OP_INSERT, 32'sh8000_0000);
      send_item(sle_pkg::OP_INSERT, 32'sd0);
      send_item(sle_pkg::OP_INSERT, 32'sd0);
      send_item(sle_pkg::OP_QUERY, 32'sh8000_0000);
      send_item(sle_pkg::OP_QUERY, 32'sd1);
      send_item(sle_pkg::OP_REMOVE, 32'sd0);
      send_item(sle_pkg::OP_REMOVE, -32'sd1);
      for (int i = 0; i < LIST_DEPTH - 3; i++) begin
         send_item(sle_pkg::OP_INSERT,
                   (i % 2) ? sle_pkg::VALUE_W'(i) : sle_pkg::VALUE_W'(-i));
      end
      send_item(sle_pkg::OP_INSERT, 32'sd42);
      send_item(sle_pkg::OP_NOP, 32'sh7fff_ffff);
      send_item(sle_pkg::OP_REMOVE, 32'sh7fff_ffff);
      drain_list();

      run_random(ITEMS_PER_PHASE);
      drain_list();
      sender_idle_pct = 66;
      run_random(ITEMS_PER_PHASE);
      drain_list();
      sender_idle_pct = 0;
      receiver_stall_pct = 66;
      run_random(ITEMS_PER_PHASE);
      drain_list();
      sender_idle_pct = 13;
      receiver_stall_pct = 13;
      run_random(ITEMS_PER_PHASE);

      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      drain_list();
      repeat (LIST_DEPTH + 8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/sle_pkg.sv
hdl/sle_cell.sv
hdl/sorted_list_engine_top.sv
tb/testbench.sv
